// ===== src/ybc_pkg.sv =====
// Shared types, register indexes and pixel arithmetic for the YUV 4:2:0 to BGR converter.
`default_nettype none
package ybc_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 26;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned POS_W      = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_OUT_CAPACITY = 2'd2
  } cfg_reg_t;

  localparam logic [DIM_W-1:0]      FRAME_WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0]      FRAME_HEIGHT_RST = 13'd480;
  localparam logic [CFG_DATA_W-1:0] OUT_CAPACITY_RST = 26'd921600;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]       first_byte;
    logic [7:0]       second_byte;
    logic [7:0]       third_byte;
    logic [POS_W-1:0] dest_row;
    logic [POS_W-1:0] dest_col;
    logic             frame_end;
  } out_beat_t;

  // chroma pair as held in the line store: Cb high, Cr low
  typedef struct packed {
    logic [7:0] cb;
    logic [7:0] cr;
  } chroma_pair_t;

  // floor(t/256) saturated to 0..255
  function automatic logic [7:0] q8_clamp(input logic signed [19:0] t);
    logic signed [11:0] q;
    q = 12'(t >>> 8);
    if (q < 0) begin
      return 8'd0;
    end else if (q > 12'sd255) begin
      return 8'd255;
    end else begin
      return q[7:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== src/yuv420_to_bgr_bottom_up_converter_top.sv =====
// Top level of the YUV 4:2:0 to BGR/RGB converter with chroma line store.
//
// Luma beats enter on in_* in raster order; on even rows at even columns the
// beat also carries the Cb/Cr pair of its 2x2 block, which goes into the
// chroma line store and is read back by the odd row below. Each accepted beat
// yields one pixel beat on out_* unless out_capacity_bytes is below
// width*height*3, in which case counters and line store advance silently.
// From input accept to out_valid the line store access is registered first,
// then the colour arithmetic is registered into the output register.
// Throughput is one pixel per cycle while in_ready is high, limited by the
// single line store port. If out_ready is low the output register holds and
// the two stages stall together; in_ready drops while a held output waits.
// cfg_* writes a register by index (0 width, 1 height, 2 capacity); after a
// write in_ready also stays low while the capacity check settles.
// Reset (rst_n low, synchronous) returns the registers to 640x480 with
// capacity 921600, clears the pixel position and empties the pipeline; the
// line store is not cleared and needs no clearing pass.
`default_nettype none
module yuv420_to_bgr_bottom_up_converter_top #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output      logic                                in_ready,
  input  wire ybc_pkg::in_beat_t                   in_data,
  output      logic                                out_valid,
  input  wire logic                                out_ready,
  output      ybc_pkg::out_beat_t                  out_data,
  input  wire logic                                cfg_valid,
  output      logic                                cfg_ready,
  input  wire logic [ybc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [ybc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import ybc_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned AW    = WW + HW;
  localparam int unsigned DEPTH = MAX_WIDTH / 2;
  localparam int unsigned IW    = $clog2(DEPTH);
  localparam int unsigned W_RST = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH
                                  : FRAME_WIDTH_RST;
  localparam int unsigned H_RST = (FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT
                                  : FRAME_HEIGHT_RST;

  // configuration
  logic [WW-1:0]         w_sat_r;
  logic [HW-1:0]         h_sat_r;
  logic [CFG_DATA_W-1:0] cap_r;
  logic [AW-1:0]         area_r;
  logic                  room_r;
  logic [1:0]            settle_r;
  logic [1:0]            settle_nxt;
  logic [DIM_W-1:0]      cfg_dim;
  logic [WW-1:0]         w_wr;
  logic [HW-1:0]         h_wr;
  logic [AW+1:0]         area3;
  logic                  swap;

  // position and pipeline
  logic [CW-1:0]      col_r;
  logic [CW-1:0]      col_nxt;
  logic [RW-1:0]      row_r;
  logic [RW-1:0]      row_nxt;
  logic [CW-1:0]      col0;
  logic [RW:0]        row_inc;
  logic [RW-1:0]      row0;
  logic               last_col;
  logic               last_row;
  logic               wr_pair;
  logic               en;
  logic               accept;
  logic [POS_W-1:0]   dest_row;

  logic               s1_valid_r;
  logic               s1_wr_r;
  logic               s1_swap_r;
  logic [7:0]         s1_luma_r;
  chroma_pair_t       s1_pair_r;
  logic [POS_W-1:0]   s1_row_r;
  logic [POS_W-1:0]   s1_col_r;
  logic               s1_last_r;
  chroma_pair_t       ram_rdata;
  chroma_pair_t       s1_pair;
  logic [7:0]         pix_first;
  logic [7:0]         pix_second;
  logic [7:0]         pix_third;

  logic               out_valid_r;
  out_beat_t          out_r;

  assign cfg_ready = 1'b1;
  assign cfg_dim   = cfg_data[DIM_W-1:0];

  always_comb begin
    if (cfg_dim == '0) begin
      w_wr = WW'(1);
      h_wr = HW'(1);
    end else begin
      w_wr = (32'(cfg_dim) > MAX_WIDTH)  ? WW'(MAX_WIDTH)  : WW'(cfg_dim);
      h_wr = (32'(cfg_dim) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg_dim);
    end
    area3 = {1'b0, area_r, 1'b0} + {2'b00, area_r};
    swap  = (w_sat_r[1:0] == 2'b00);
    settle_nxt = (settle_r != 2'd0) ? settle_r - 2'd1 : 2'd0;
    if (cfg_valid) begin
      settle_nxt = 2'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_sat_r  <= WW'(W_RST);
      h_sat_r  <= HW'(H_RST);
      cap_r    <= OUT_CAPACITY_RST;
      settle_r <= 2'd2;
    end else begin
      settle_r <= settle_nxt;
      if (cfg_valid) begin
        case (cfg_reg_t'(cfg_index))
          REG_FRAME_WIDTH:  w_sat_r <= w_wr;
          REG_FRAME_HEIGHT: h_sat_r <= h_wr;
          REG_OUT_CAPACITY: cap_r   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    area_r <= AW'(w_sat_r) * AW'(h_sat_r);
    room_r <= (32'(area3) <= 32'(cap_r));
  end

  // position of this pixel and of the next
  always_comb begin
    if (32'(col_r) >= 32'(w_sat_r)) begin
      col0    = '0;
      row_inc = {1'b0, row_r} + (RW+1)'(1);
    end else begin
      col0    = col_r;
      row_inc = {1'b0, row_r};
    end
    row0     = (32'(row_inc) >= 32'(h_sat_r)) ? '0 : row_inc[RW-1:0];
    last_col = (32'(col0) + 32'd1 >= 32'(w_sat_r));
    last_row = (32'(row0) + 32'd1 >= 32'(h_sat_r));
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : RW'(32'(row0) + 32'd1);
    end else begin
      col_nxt = CW'(32'(col0) + 32'd1);
      row_nxt = row0;
    end
    wr_pair  = !row0[0] && !col0[0];
    dest_row = swap ? POS_W'(32'(h_sat_r) - 32'd1 - 32'(row0)) : POS_W'(32'(row0));
  end

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en && (settle_r == 2'd0);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  ybc_ram #(
    .WIDTH ($bits(chroma_pair_t)),
    .DEPTH (DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (accept && wr_pair),
    .re    (accept && !wr_pair),
    .addr  (col0[IW:1]),
    .wdata ({in_data.chroma_blue, in_data.chroma_red}),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= accept && room_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_wr_r   <= wr_pair;
      s1_swap_r <= swap;
      s1_luma_r <= in_data.luma;
      s1_pair_r <= {in_data.chroma_blue, in_data.chroma_red};
      s1_row_r  <= dest_row;
      s1_col_r  <= POS_W'(32'(col0));
      s1_last_r <= last_col && last_row;
    end
  end

  assign s1_pair = s1_wr_r ? s1_pair_r : ram_rdata;

  ybc_pix u_pix (
    .swap        (s1_swap_r),
    .luma        (s1_luma_r),
    .pair        (s1_pair),
    .first_byte  (pix_first),
    .second_byte (pix_second),
    .third_byte  (pix_third)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s1_valid_r) begin
      out_r.first_byte  <= pix_first;
      out_r.second_byte <= pix_second;
      out_r.third_byte  <= pix_third;
      out_r.dest_row    <= s1_row_r;
      out_r.dest_col    <= s1_col_r;
      out_r.frame_end   <= s1_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ===== src/ybc_ram.sv =====
// Generic single-port synchronous RAM with registered read.
`default_nettype none
module ybc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

// ===== src/ybc_pix.sv =====
// Q8 fixed-point YCbCr to colour conversion of one pixel, with byte ordering.
`default_nettype none
module ybc_pix (
  input  wire logic                 swap,
  input  wire logic [7:0]           luma,
  input  wire ybc_pkg::chroma_pair_t pair,
  output      logic [7:0]           first_byte,
  output      logic [7:0]           second_byte,
  output      logic [7:0]           third_byte
);
  import ybc_pkg::*;

  logic signed [8:0]  ud;
  logic signed [8:0]  vd;
  logic signed [19:0] y_s;
  logic signed [19:0] t_r;
  logic signed [19:0] t_g;
  logic signed [19:0] t_b;
  logic [7:0]         r;
  logic [7:0]         g;
  logic [7:0]         b;

  always_comb begin
    ud  = $signed({1'b0, pair.cb}) - 9'sd128;
    vd  = $signed({1'b0, pair.cr}) - 9'sd128;
    y_s = $signed({4'b0, luma, 8'b0});
    t_r = y_s + 20'(vd) * 20'sd359;
    t_g = y_s - 20'(ud) * 20'sd88 - 20'(vd) * 20'sd183;
    t_b = y_s + 20'(ud) * 20'sd453;
    r   = q8_clamp(t_r);
    g   = q8_clamp(t_g);
    b   = q8_clamp(t_b);
    first_byte  = swap ? b : r;
    second_byte = g;
    third_byte  = swap ? r : b;
  end

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the YUV 4:2:0 to BGR/RGB converter: queued driver, monitor, predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ybc_pkg::*;

  localparam int unsigned MAX_W         = 4096;
  localparam int unsigned MAX_H         = 4096;
  localparam int unsigned STORE_DEPTH   = MAX_W / 2;
  localparam int unsigned RANDOM_PIXELS = 1050;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned CAP_MAX       = 67108863;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_beat_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_beat_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_reg_t              cfg_index = REG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  yuv420_to_bgr_bottom_up_converter_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  in_beat_t  pending_pixels[$];
  out_beat_t expected_pixels[$];

  // predictor state
  logic [DIM_W-1:0]      cur_width    = FRAME_WIDTH_RST;
  logic [DIM_W-1:0]      cur_height   = FRAME_HEIGHT_RST;
  logic [CFG_DATA_W-1:0] cur_capacity = OUT_CAPACITY_RST;
  chroma_pair_t          chroma_mem [STORE_DEPTH];
  int unsigned           pix_col = 0;
  int unsigned           pix_row = 0;

  // position of the next queued pixel, and how much of the line store has been written
  int unsigned feed_col     = 0;
  int unsigned feed_row     = 0;
  int unsigned chroma_reach = 0;

  int unsigned mismatches  = 0;
  int unsigned cycles      = 0;
  int unsigned random_sent = 0;
  int unsigned in_gap      = 0;
  int unsigned out_stall   = 0;
  logic        steady      = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned clip_dim(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void wrap_pos(inout int unsigned col, inout int unsigned row,
                                   input int unsigned w, input int unsigned h);
    if (col >= w) begin
      col = 0;
      row++;
    end
    if (row >= h) row = 0;
  endfunction

  function automatic void advance_pos(inout int unsigned col, inout int unsigned row,
                                      input int unsigned w, input int unsigned h);
    if (col + 1 >= w) begin
      col = 0;
      row = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      col++;
    end
  endfunction

  function automatic logic [7:0] sat8(int t);
    int q;
    q = t >>> 8;
    if (q < 0) return 8'd0;
    if (q > 255) return 8'd255;
    return 8'(q);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void convert_pixel(in_beat_t px);
    int unsigned  w, h, col, row, idx;
    int           luma, ud, vd;
    chroma_pair_t pair;
    logic [7:0]   red, green, blue;
    logic         swap;
    out_beat_t    beat;
    w = clip_dim(cur_width, MAX_W);
    h = clip_dim(cur_height, MAX_H);
    wrap_pos(pix_col, pix_row, w, h);
    col = pix_col;
    row = pix_row;
    idx = (col >> 1) % STORE_DEPTH;
    if ((row % 2) == 0 && (col % 2) == 0) begin
      chroma_mem[idx] = '{cb: px.chroma_blue, cr: px.chroma_red};
    end
    pair  = chroma_mem[idx];
    luma  = int'(px.luma);
    ud    = int'(pair.cb) - 128;
    vd    = int'(pair.cr) - 128;
    red   = sat8(256 * luma + 359 * vd);
    green = sat8(256 * luma - 88 * ud - 183 * vd);
    blue  = sat8(256 * luma + 453 * ud);
    swap  = (w % 4) == 0;
    beat.first_byte  = swap ? blue : red;
    beat.second_byte = green;
    beat.third_byte  = swap ? red : blue;
    beat.dest_row    = POS_W'(swap ? h - 1 - row : row);
    beat.dest_col    = POS_W'(col);
    beat.frame_end   = (col + 1 >= w) && (row + 1 >= h);
    advance_pos(pix_col, pix_row, w, h);
    if (longint'(cur_capacity) >= longint'(w) * longint'(h) * 3) begin
      expected_pixels.push_back(beat);
    end
  endfunction

  function automatic void cmp_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_pixel(out_beat_t got);
    out_beat_t want;
    if (expected_pixels.size() == 0) begin
      $error("output beat with no pixel pending");
      mismatches++;
      return;
    end
    want = expected_pixels.pop_front();
    cmp_field("first_byte", want.first_byte, got.first_byte);
    cmp_field("second_byte", want.second_byte, got.second_byte);
    cmp_field("third_byte", want.third_byte, got.third_byte);
    cmp_field("dest_row", want.dest_row, got.dest_row);
    cmp_field("dest_col", want.dest_col, got.dest_col);
    cmp_field("frame_end", want.frame_end, got.frame_end);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) convert_pixel(in_data);
      if (in_gap > 0) begin
        in_gap   <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_pixels.size() > 0) begin
        in_data  <= pending_pixels.pop_front();
        in_valid <= 1'b1;
        in_gap   <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_pixel(out_data);
      if (out_stall > 0) begin
        out_stall <= out_stall - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_stall <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("yuv420_to_bgr_bottom_up_converter_top verification failed");
      $finish;
    end
  end

  function automatic logic [7:0] rand_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12) return 8'd0;
    if (r < 24) return 8'd255;
    if (r < 32) return 8'd128;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic int unsigned pick_dim();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 12);
    if (r < 82) return $urandom_range(13, 80);
    if (r < 88) return 0;
    if (r < 93) return $urandom_range(MAX_W + 1, 8191);
    return $urandom_range(81, MAX_W);
  endfunction

  function automatic void push_pixel(logic [7:0] y, logic [7:0] cb, logic [7:0] cr);
    int unsigned w, h, idx;
    in_beat_t    px;
    w = clip_dim(cur_width, MAX_W);
    h = clip_dim(cur_height, MAX_H);
    wrap_pos(feed_col, feed_row, w, h);
    idx = (feed_col >> 1) % STORE_DEPTH;
    if ((feed_row % 2) == 0 && (feed_col % 2) == 0 && idx >= chroma_reach) begin
      chroma_reach = idx + 1;
    end
    advance_pos(feed_col, feed_row, w, h);
    px.luma        = y;
    px.chroma_blue = cb;
    px.chroma_red  = cr;
    pending_pixels.push_back(px);
  endfunction

  task automatic wait_idle();
    while (pending_pixels.size() != 0 || in_valid || expected_pixels.size() != 0) begin
      @(posedge clk);
    end
    // suppressed pixels leave no beat behind, so allow the pipeline to drain
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_FRAME_WIDTH: cur_width = val[DIM_W-1:0];
      REG_FRAME_HEIGHT: cur_height = val[DIM_W-1:0];
      REG_OUT_CAPACITY: cur_capacity = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input int unsigned w, input int unsigned h,
                           input longint unsigned cap);
    int unsigned c, r, wq, hq;
    wait_idle();
    wq = clip_dim(w, MAX_W);
    hq = clip_dim(h, MAX_H);
    c  = feed_col;
    r  = feed_row;
    wrap_pos(c, r, wq, hq);
    // an odd row may only read line store entries already written
    if ((r % 2) == 1 && ((wq - 1) >> 1) >= chroma_reach) w = 2 * chroma_reach;
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_OUT_CAPACITY, CFG_DATA_W'(cap));
    steady <= ($urandom_range(0, 3) == 0);
  endtask

  initial begin
    int unsigned     n, w, h, pick;
    longint unsigned need, cap;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: 640x480, capacity exactly enough, BGR with flipped rows
    push_pixel(8'd0, 8'd0, 8'd0);
    push_pixel(8'd255, 8'd255, 8'd255);
    push_pixel(8'd255, 8'd255, 8'd255);
    push_pixel(8'd0, 8'd0, 8'd0);
    push_pixel(8'd128, 8'd128, 8'd128);
    push_pixel(8'd16, 8'd0, 8'd255);
    push_pixel(8'd235, 8'd255, 8'd0);
    push_pixel(8'd0, 8'd255, 8'd0);

    // narrower mid-frame: wraps straight into an odd row; odd height, RGB order
    configure(2, 3, 18);
    repeat (6) push_pixel(rand_byte(), rand_byte(), rand_byte());

    // odd width
    configure(3, 2, 18);
    repeat (6) push_pixel(rand_byte(), rand_byte(), rand_byte());

    // capacity one byte short
    configure(4, 2, 23);
    repeat (3) push_pixel(rand_byte(), rand_byte(), rand_byte());

    // zero width and height saturate to 1x1
    configure(0, 0, 3);
    repeat (2) push_pixel(8'd255, 8'd0, 8'd255);

    // oversize values saturate to 4096x4096
    configure(8191, 8191, 50331648);
    repeat (2) push_pixel(8'd0, 8'd255, 8'd0);

    configure(MAX_W, 1, CAP_MAX);
    repeat (2) push_pixel(rand_byte(), rand_byte(), rand_byte());

    while (random_sent < RANDOM_PIXELS) begin
      w    = pick_dim();
      h    = pick_dim();
      need = longint'(clip_dim(w, MAX_W)) * longint'(clip_dim(h, MAX_H)) * 3;
      pick = $urandom_range(0, 99);
      if (pick < 78) cap = need + $urandom_range(0, 1000);
      else if (pick < 86) cap = need;
      else if (pick < 94) cap = need - 1;
      else cap = $urandom_range(0, CAP_MAX);
      configure(w, h, cap);
      n = $urandom_range(4, 50);
      repeat (n) push_pixel(rand_byte(), rand_byte(), rand_byte());
      random_sent += n;
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("yuv420_to_bgr_bottom_up_converter_top verification clean");
    end else begin
      $display("yuv420_to_bgr_bottom_up_converter_top verification failed");
    end
    $finish;
  end

endmodule
